// File: rtl/mbfla_pkg.sv
// Shared types and constants for the multi-bank free-list allocator.
package mbfla_pkg;

  // Bank geometry; the port widths below cover these sizes
  localparam int BANK_COUNT     = 4;
  localparam int SLOTS_PER_BANK = 256;

  // Fixed field widths of the request and response words
  localparam int OP_W     = 1;
  localparam int BANK_W   = 2;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 3;

  // Reset value of the banks-in-use register
  localparam logic [CFG_W-1:0] BANKS_RESET = 3'd4;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_DROP = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the request word
    logic exec;   // search, pop or push, issue queue read
    logic resp;   // present the response word
  } ctl_cmd_t;

endpackage

// File: rtl/mbfla_ctrl.sv
// Controller state machine for the multi-bank free-list allocator.
module mbfla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output mbfla_pkg::ctl_cmd_t cmd
);

  mbfla_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbfla_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    cmd        = '0;
    case (state)
      mbfla_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = mbfla_pkg::S_EXEC;
        end
      end
      mbfla_pkg::S_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = mbfla_pkg::S_RESP;
      end
      mbfla_pkg::S_RESP: begin
        // response goes out while the next word may already be taken
        cmd.resp = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = mbfla_pkg::S_EXEC;
        end else begin
          state_next = mbfla_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mbfla_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/mbfla_dp.sv
// Datapath for the multi-bank free-list allocator: queue pointers, counts and slot memory.
module mbfla_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mbfla_pkg::ctl_cmd_t                 cmd,
  input  logic [mbfla_pkg::CFG_W-1:0]         banks_in_use,
  input  logic [mbfla_pkg::OP_W-1:0]          opcode,
  input  logic [mbfla_pkg::BANK_W-1:0]        release_bank,
  input  logic [mbfla_pkg::SLOT_W-1:0]        release_slot,
  output logic                                done,
  output logic [mbfla_pkg::STATUS_W-1:0]      status,
  output logic [mbfla_pkg::BANK_W-1:0]        grant_bank,
  output logic [mbfla_pkg::SLOT_W-1:0]        grant_slot
);

  localparam int BANK_COUNT     = mbfla_pkg::BANK_COUNT;
  localparam int SLOTS_PER_BANK = mbfla_pkg::SLOTS_PER_BANK;
  localparam int BankW   = mbfla_pkg::BANK_W;
  localparam int SlotW   = mbfla_pkg::SLOT_W;
  localparam int StatusW = mbfla_pkg::STATUS_W;
  localparam int BiW     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int SiW     = $clog2(SLOTS_PER_BANK);
  localparam int CntW    = $clog2(SLOTS_PER_BANK + 1);
  localparam int Depth   = BANK_COUNT * SLOTS_PER_BANK;
  localparam int AddrW   = $clog2(Depth);
  localparam logic [CntW-1:0] FullCnt = CntW'(SLOTS_PER_BANK);

  // Latched request word
  logic [mbfla_pkg::OP_W-1:0] req_op;
  logic [BankW-1:0]           req_bank;
  logic [SlotW-1:0]           req_slot;

  // Per-bank queue state; wrapped marks a bank whose whole queue has been rewritten
  logic [SiW-1:0]  head    [BANK_COUNT];
  logic [SiW-1:0]  tail    [BANK_COUNT];
  logic [CntW-1:0] count   [BANK_COUNT];
  logic            wrapped [BANK_COUNT];

  // Slot storage
  logic [SiW-1:0] mem [Depth];
  logic [SiW-1:0] rd_data;

  // Response registers
  mbfla_pkg::status_t rsp_status;
  logic [BiW-1:0]     rsp_bank;
  logic               rsp_from_mem;
  logic [SiW-1:0]     rsp_head;

  // Search and release decode
  logic           sel_found;
  logic [BiW-1:0] sel_bank;
  logic [BiW-1:0] rel_bank;
  logic           rel_ok;
  logic [SiW-1:0] sel_head;
  logic [SiW-1:0] rel_tail;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic           is_alloc;

  assign is_alloc = (req_op == mbfla_pkg::OP_ALLOC);
  assign rel_bank = BiW'(req_bank);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= opcode;
      req_bank <= release_bank;
      req_slot <= release_slot;
    end
  end

  // Priority search over searched banks with free slots; zero searches bank 0
  always_comb begin
    sel_found = 1'b0;
    sel_bank  = '0;
    for (int b = 0; b < BANK_COUNT; b++) begin
      if (!sel_found && count[b] != '0 &&
          ((banks_in_use == '0 && b == 0) || b < int'(banks_in_use))) begin
        sel_found = 1'b1;
        sel_bank  = BiW'(b);
      end
    end
  end

  // Release checks: bank exists, slot in range, queue not full
  always_comb begin
    rel_ok = 1'b0;
    if (int'(req_bank) < BANK_COUNT && int'(req_slot) < SLOTS_PER_BANK) begin
      rel_ok = (count[rel_bank] != FullCnt);
    end
  end

  assign sel_head = head[sel_bank];
  assign rel_tail = tail[rel_bank];
  assign rd_addr  = AddrW'(int'(sel_bank) * SLOTS_PER_BANK + int'(sel_head));
  assign wr_addr  = AddrW'(int'(rel_bank) * SLOTS_PER_BANK + int'(rel_tail));

  // Slot memory: one read or one write per request
  always_ff @(posedge clk) begin
    if (cmd.exec && is_alloc) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.exec && !is_alloc && rel_ok) begin
      mem[wr_addr] <= SiW'(req_slot);
    end
  end

  // Queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANK_COUNT; b++) begin
        head[b]    <= '0;
        tail[b]    <= '0;
        count[b]   <= FullCnt;
        wrapped[b] <= 1'b0;
      end
    end else if (cmd.exec) begin
      if (is_alloc && sel_found) begin
        // pop front
        head[sel_bank]  <= (int'(sel_head) + 1 >= SLOTS_PER_BANK) ? '0 : sel_head + 1'b1;
        count[sel_bank] <= count[sel_bank] - 1'b1;
      end else if (!is_alloc && rel_ok) begin
        // push back; past the last entry every entry holds written data
        if (int'(rel_tail) + 1 >= SLOTS_PER_BANK) begin
          tail[rel_bank]    <= '0;
          wrapped[rel_bank] <= 1'b1;
        end else begin
          tail[rel_bank] <= rel_tail + 1'b1;
        end
        count[rel_bank] <= count[rel_bank] + 1'b1;
      end
    end
  end

  // Response capture; entries never written still hold their reset slot number
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_bank     <= sel_bank;
      rsp_head     <= sel_head;
      rsp_from_mem <= wrapped[sel_bank] || (sel_head < tail[sel_bank]);
      if (is_alloc) begin
        rsp_status <= sel_found ? mbfla_pkg::ST_OK : mbfla_pkg::ST_OOM;
      end else begin
        rsp_status <= rel_ok ? mbfla_pkg::ST_OK : mbfla_pkg::ST_DROP;
      end
      if (!is_alloc) begin
        rsp_bank <= '0;
      end
    end
  end

  // Response word; grant fields are zero unless an allocate succeeded
  logic grant_valid;
  assign grant_valid = cmd.resp && (rsp_status == mbfla_pkg::ST_OK) && is_alloc;

  assign done       = cmd.resp;
  assign status     = cmd.resp ? StatusW'(rsp_status) : '0;
  assign grant_bank = grant_valid ? BankW'(rsp_bank) : '0;
  assign grant_slot = grant_valid ? SlotW'(rsp_from_mem ? rd_data : rsp_head) : '0;

endmodule

// File: rtl/multi_bank_free_list_allocator.sv
// Top level of the multi-bank free-list allocator.
//
// Channel   Direction  Signals                                  Handshake
// request   in         opcode, release_bank, release_slot        start & !busy
// response  out        status, grant_bank, grant_slot            done, one cycle
// config    in         cfg_data (banks_in_use)                   cfg_write
//
// A word first passes through S_EXEC, the bank search and queue update,
// which issues the slot memory read, then S_RESP, in which the registered
// read data form the response. A new word is taken in the cycle its
// predecessor's response is shown.
// Reset sets every queue full with slots in order; no clearing pass is
// needed since unwritten entries are tracked by each bank's tail mark.
// The response cannot be stalled.
module multi_bank_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [mbfla_pkg::OP_W-1:0]     opcode,
  input  logic [mbfla_pkg::BANK_W-1:0]   release_bank,
  input  logic [mbfla_pkg::SLOT_W-1:0]   release_slot,
  output logic                           done,
  output logic [mbfla_pkg::STATUS_W-1:0] status,
  output logic [mbfla_pkg::BANK_W-1:0]   grant_bank,
  output logic [mbfla_pkg::SLOT_W-1:0]   grant_slot,
  input  logic                           cfg_write,
  input  logic [mbfla_pkg::CFG_W-1:0]    cfg_data
);

  mbfla_pkg::ctl_cmd_t             cmd;
  logic [mbfla_pkg::CFG_W-1:0]     banks_in_use;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      banks_in_use <= mbfla_pkg::BANKS_RESET;
    end else if (cfg_write) begin
      banks_in_use <= cfg_data;
    end
  end

  // Controller
  mbfla_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath
  mbfla_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .banks_in_use (banks_in_use),
    .opcode       (opcode),
    .release_bank (release_bank),
    .release_slot (release_slot),
    .done         (done),
    .status       (status),
    .grant_bank   (grant_bank),
    .grant_slot   (grant_slot)
  );

endmodule
